>>> rtl/prfe_pkg.sv
`timescale 1ns / 1ps

package prfe_pkg;

  // palette geometry
  localparam int ENTRIES = 256;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int NCH     = 3;
  localparam int CHSEL_W = 2;
  localparam logic [CHSEL_W-1:0] LAST_CH = CHSEL_W'(NCH - 1);

  // shared divider
  localparam int DIV_W   = CH_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  // fill stepping widths: remainder accumulator runs below four times the span
  localparam int RACC_W  = IDX_W + 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RAMP  = 2'd2,
    OP_SPLIT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_RWAIT,
    ST_LOAD_S,
    ST_LOAD_E,
    ST_LOAD_WAIT,
    ST_MID,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FILL,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [CH_W-1:0] get_chan(input logic [COLOR_W-1:0] color,
                                               input logic [CHSEL_W-1:0] ch);
    logic [CH_W-1:0] res;
    case (ch)
      2'd0:    res = color[CH_W-1:0];
      2'd1:    res = color[2*CH_W-1:CH_W];
      2'd2:    res = color[3*CH_W-1:2*CH_W];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/prfe_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module prfe_div import prfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [DIV_W-1:0] rem
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, quo[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[DIV_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

>>> rtl/prfe_mem.sv
`timescale 1ns / 1ps

// palette store, entries not yet written read as zero
module prfe_mem import prfe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mem_req_t           req,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [COLOR_W-1:0] rd_raw;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_raw <= mem[req.raddr];
    rd_vld <= vld[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd_raw : '0;

endmodule

>>> rtl/palette_ramp_fill_engine_unit.sv
`timescale 1ns / 1ps

// channel  dir  fields (lsb first)
// s_*      in   tuser: opcode[1:0]; tdata: entry_index, range_start, range_end, write_color
// m_*      out  tuser: status; tdata: read_color
//
// one request at a time; s_tready is high only while the sequencer is idle
// a ramp reads both endpoints, runs three divisions on the shared divider, then
// makes one palette write per cycle; a split runs the divisions and the fill
// for each of its two halves in turn
// reset clears every palette entry at once through per-entry valid bits
// a finished result waits in the output register until m_tready; the next
// request is taken as soon as it has been loaded

module palette_ramp_fill_engine_unit import prfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,   // opcode
  input  logic [47:0]           s_tdata,   // entry_index, range_start, range_end, write_color
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [0:0]            m_tuser,   // status
  output logic [COLOR_W-1:0]    m_tdata    // read_color
);

  // request fields
  op_t                in_op;
  logic [IDX_W-1:0]   in_idx, in_s, in_e;
  logic [COLOR_W-1:0] in_wc;

  assign in_op  = op_t'(s_tuser);
  assign in_idx = s_tdata[7:0];
  assign in_s   = s_tdata[15:8];
  assign in_e   = s_tdata[23:16];
  assign in_wc  = s_tdata[47:24];

  st_t state, state_next;

  // latched request
  op_t                op;
  logic [IDX_W-1:0]   idx, rs, re;
  logic [COLOR_W-1:0] wc;

  // result
  logic [COLOR_W-1:0] res_color;
  logic               res_status;

  // segment being filled
  logic [COLOR_W-1:0] cs, ce, lo, hi;
  logic [IDX_W-1:0]   seg_s, seg_e, pos;
  logic [IDX_W-1:0]   seg_n;
  logic               phase;
  logic [CHSEL_W-1:0] ch;

  // per-channel stepping state: value offset, remainder, step quotient and remainder
  logic [CH_W-1:0]    q   [NCH];
  logic [RACC_W-1:0]  r   [NCH];
  logic [CH_W-1:0]    qd  [NCH];
  logic [RACC_W-1:0]  rd  [NCH];
  logic               neg [NCH];

  logic [CH_W-1:0]    q_step [NCH];
  logic [RACC_W-1:0]  r_step [NCH];
  logic [COLOR_W-1:0] fill_color;
  logic [RACC_W-1:0]  two_n;

  logic [COLOR_W-1:0] avg;
  logic [CH_W-1:0]    lo_ch, hi_ch;

  mem_req_t           mreq;
  logic [COLOR_W-1:0] rdata;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_quo, div_rem, div_dvd;

  logic               accept, in_ok, seg_end, next_seg, out_load;

  assign accept = s_tvalid && s_tready;
  assign seg_n  = seg_e - seg_s;
  assign two_n  = {1'b0, seg_n, 1'b0};
  assign lo_ch  = get_chan(lo, ch);
  assign hi_ch  = get_chan(hi, ch);
  assign div_dvd = (hi_ch < lo_ch) ? (lo_ch - hi_ch) : (hi_ch - lo_ch);

  // range checks on the incoming request
  always_comb begin
    case (in_op)
      OP_WRITE, OP_READ: in_ok = 32'(in_idx) < 32'(ENTRIES);
      OP_RAMP:           in_ok = (in_s < in_e) && (32'(in_e) < 32'(ENTRIES));
      OP_SPLIT:          in_ok = (in_s < in_idx) && (in_idx < in_e)
                                 && (32'(in_e) < 32'(ENTRIES));
      default:           in_ok = 1'b0;
    endcase
  end

  // truncated per-channel average of the endpoints
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      avg[c*CH_W +: CH_W] = CH_W'(({1'b0, cs[c*CH_W +: CH_W]}
                                  + {1'b0, ce[c*CH_W +: CH_W]}) >> 1);
    end
  end

  // incremental rounding: offset k = floor((2dk + n) / 2n), stepped by d/n
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      logic [RACC_W-1:0] rsum;
      logic              carry;
      rsum      = r[c] + rd[c];
      carry     = rsum >= two_n;
      r_step[c] = carry ? (rsum - two_n) : rsum;
      q_step[c] = q[c] + qd[c] + CH_W'(carry);
      fill_color[c*CH_W +: CH_W] = neg[c] ? (lo[c*CH_W +: CH_W] - q_step[c])
                                          : (lo[c*CH_W +: CH_W] + q_step[c]);
    end
  end

  assign seg_end = ((state == ST_FILL) && (pos == seg_e - 1'b1))
                || ((state == ST_DIV_WAIT) && div_done && (ch == LAST_CH)
                    && (seg_n == IDX_W'(1)));
  assign next_seg = seg_end && (op == OP_SPLIT) && !phase;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // sequencer: next state and memory / divider controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mreq.we    = 1'b0;
    mreq.waddr = ADDR_W'(idx);
    mreq.wdata = wc;
    mreq.raddr = ADDR_W'(idx);
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!in_ok) begin
            state_next = ST_DONE;
          end else begin
            case (in_op)
              OP_WRITE: state_next = ST_WRITE;
              OP_READ:  state_next = ST_READ;
              default:  state_next = ST_LOAD_S;
            endcase
          end
        end
      end
      ST_WRITE: begin
        mreq.we    = 1'b1;
        state_next = ST_DONE;
      end
      ST_READ:  state_next = ST_RWAIT;
      ST_RWAIT: state_next = ST_DONE;
      ST_LOAD_S: begin
        mreq.raddr = ADDR_W'(rs);
        state_next = ST_LOAD_E;
      end
      ST_LOAD_E: begin
        mreq.raddr = ADDR_W'(re);
        state_next = ST_LOAD_WAIT;
      end
      ST_LOAD_WAIT: state_next = (op == OP_SPLIT) ? ST_MID : ST_DIV_START;
      ST_MID: begin
        mreq.we    = 1'b1;
        mreq.wdata = avg;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (ch != LAST_CH) begin
            state_next = ST_DIV_START;
          end else if (seg_end) begin
            state_next = next_seg ? ST_DIV_START : ST_DONE;
          end else begin
            state_next = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        mreq.we    = 1'b1;
        mreq.waddr = ADDR_W'(pos);
        mreq.wdata = fill_color;
        if (seg_end) begin
          state_next = next_seg ? ST_DIV_START : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= in_op;
      idx        <= in_idx;
      rs         <= in_s;
      re         <= in_e;
      wc         <= in_wc;
      res_color  <= '0;
      res_status <= in_ok ? STATUS_OK : STATUS_BAD;
      phase      <= 1'b0;
    end
    // second half of a split: middle entry becomes the low endpoint
    if (next_seg) begin
      phase <= 1'b1;
      lo    <= hi;
      hi    <= ce;
      seg_s <= idx;
      seg_e <= re;
      ch    <= '0;
    end else begin
      case (state)
        ST_RWAIT:  res_color <= rdata;
        ST_LOAD_E: cs <= rdata;
        ST_LOAD_WAIT: begin
          ce    <= rdata;
          lo    <= cs;
          hi    <= rdata;
          seg_s <= rs;
          seg_e <= re;
          ch    <= '0;
        end
        ST_MID: begin
          hi    <= avg;
          seg_e <= idx;
        end
        ST_DIV_START: neg[ch] <= hi_ch < lo_ch;
        ST_DIV_WAIT: begin
          if (div_done) begin
            qd[ch] <= div_quo;
            rd[ch] <= RACC_W'({div_rem, 1'b0});
            q[ch]  <= '0;
            r[ch]  <= RACC_W'(seg_n);
            ch     <= ch + 1'b1;
            pos    <= seg_s + 1'b1;
          end
        end
        ST_FILL: begin
          for (int c = 0; c < NCH; c++) begin
            q[c] <= q_step[c];
            r[c] <= r_step[c];
          end
          pos <= pos + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= res_color;
      m_tuser[0] <= res_status;
    end
  end

  prfe_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

  prfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (seg_n),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

endmodule

>>> rtl/prfe_chk.sv
`timescale 1ns / 1ps

module prfe_chk import prfe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [0:0]         m_tuser,
  input logic [COLOR_W-1:0] m_tdata
);

  // one request in flight: no second request on the cycle after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");

  // a rejected request never returns colour data
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == STATUS_BAD) |-> m_tdata == '0)
    else $error("colour returned with error status");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind palette_ramp_fill_engine_unit prfe_chk u_chk (.*);
